// File: rtl/qph_pkg.sv
package qph_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SUM_W       = SLOT_W + 1;
   localparam int STEP_W      = $clog2(TABLE_SLOTS + 1);
   localparam int KEY_W       = 31;
   localparam int VAL_W       = 32;
   localparam int BIT_W       = $clog2(KEY_W);
   localparam int ENTRY_W     = KEY_W + VAL_W;
   localparam bit SLOT_POW2   = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
   localparam logic [SLOT_W-1:0] ODD_INIT = SLOT_W'(1 % TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] TWO_MOD  = SLOT_W'(2 % TABLE_SLOTS);

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_SEARCH = 1'b1
   } qph_action_type;

   typedef enum logic [1:0] {
      STAT_STORED  = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_FOUND   = 2'd2,
      STAT_MISSING = 2'd3
   } qph_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HOME,
      S_PROBE
   } qph_state_type;

   typedef struct packed {
      qph_action_type   action;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } qph_req_type;

   typedef struct packed {
      qph_status_type   status;
      logic [VAL_W-1:0] found_value;
   } qph_rsp_type;

   // (a + b) mod TABLE_SLOTS for a, b already below TABLE_SLOTS
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
      logic [SUM_W-1:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= SUM_W'(TABLE_SLOTS)) begin
         s = s - SUM_W'(TABLE_SLOTS);
      end
      return s[SLOT_W-1:0];
   endfunction

endpackage

// File: rtl/quadratic_probe_hash_table.sv
// Open-addressed hash table, quadratic probing, TABLE_SLOTS slots of 31-bit key and
// 32-bit value held in one single-port-read RAM; occupied bits are flip-flops cleared by
// reset. A request is taken when start is high and busy is low. Probes are issued one per
// cycle, each RAM read checked in the cycle after it, and busy stays high until the request
// ends, so the next request can be taken only once busy is low again. When TABLE_SLOTS is
// not a power of two the home slot is first reduced one key bit per cycle. The result shows
// on rsp_data for exactly one cycle with rsp_valid, the first cycle that busy is low; it must
// be taken then.
module quadratic_probe_hash_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  qph_pkg::qph_req_type req_data,
   output logic                 rsp_valid,
   output qph_pkg::qph_rsp_type rsp_data
);

   import qph_pkg::*;

   qph_state_type     state_ff, state_in;
   qph_req_type       req_ff, req_in;
   logic [SLOT_W-1:0] home_ff, home_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [SLOT_W-1:0] sq_ff, sq_in;
   logic [SLOT_W-1:0] odd_ff, odd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              chk_vld_ff, chk_vld_in;
   logic              chk_used_ff, chk_used_in;
   logic              chk_last_ff, chk_last_in;
   logic [SLOT_W-1:0] chk_slot_ff, chk_slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   qph_rsp_type       rsp_ff, rsp_in;
   logic [TABLE_SLOTS-1:0] used_ff;

   logic               rd_en;
   logic               wr_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [VAL_W-1:0]   rd_value;
   logic               key_match;
   logic               done;
   logic [SUM_W-1:0]   rem_shift;
   logic [SLOT_W-1:0]  rem_next;

   qph_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_SLOTS)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(chk_slot_ff),
      .wr_data({req_ff.key, req_ff.value}),
      .rd_en  (rd_en),
      .rd_addr(cur_slot_ff),
      .rd_data(rd_data)
   );

   assign rd_key    = rd_data[ENTRY_W-1:VAL_W];
   assign rd_value  = rd_data[VAL_W-1:0];
   assign key_match = chk_used_ff && (rd_key == req_ff.key);
   assign done      = chk_vld_ff && (!chk_used_ff || key_match || chk_last_ff);

   assign rem_shift = {rem_ff, req_ff.key[bit_ff]};
   assign rem_next  = (rem_shift >= SUM_W'(TABLE_SLOTS)) ?
                      SLOT_W'(rem_shift - SUM_W'(TABLE_SLOTS)) : SLOT_W'(rem_shift);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      home_in      = home_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      cur_slot_in  = cur_slot_ff;
      sq_in        = sq_ff;
      odd_in       = odd_ff;
      step_in      = step_ff;
      chk_vld_in   = 1'b0;
      chk_used_in  = chk_used_ff;
      chk_last_in  = chk_last_ff;
      chk_slot_in  = chk_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in  = req_data;
               sq_in   = '0;
               odd_in  = ODD_INIT;
               step_in = '0;
               rem_in  = '0;
               bit_in  = BIT_W'(KEY_W - 1);
               if (SLOT_POW2) begin
                  home_in     = req_data.key[SLOT_W-1:0];
                  cur_slot_in = req_data.key[SLOT_W-1:0];
                  state_in    = S_PROBE;
               end else begin
                  state_in = S_HOME;
               end
            end
         end
         S_HOME: begin
            rem_in = rem_next;
            if (bit_ff == '0) begin
               home_in     = rem_next;
               cur_slot_in = rem_next;
               state_in    = S_PROBE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         S_PROBE: begin
            if (done) begin
               state_in            = S_IDLE;
               rsp_valid_in        = 1'b1;
               rsp_in.found_value  = '0;
               if (req_ff.action == ACT_INSERT) begin
                  if (!chk_used_ff || key_match) begin
                     wr_en         = 1'b1;
                     rsp_in.status = STAT_STORED;
                  end else begin
                     rsp_in.status = STAT_FULL;
                  end
               end else begin
                  if (key_match) begin
                     rsp_in.status      = STAT_FOUND;
                     rsp_in.found_value = rd_value;
                  end else begin
                     rsp_in.status = STAT_MISSING;
                  end
               end
            end else if (step_ff < STEP_W'(TABLE_SLOTS)) begin
               rd_en       = 1'b1;
               chk_vld_in  = 1'b1;
               chk_slot_in = cur_slot_ff;
               chk_used_in = used_ff[cur_slot_ff];
               chk_last_in = (step_ff == STEP_W'(TABLE_SLOTS - 1));
               step_in     = step_ff + 1'b1;
               sq_in       = slot_add(sq_ff, odd_ff);
               odd_in      = slot_add(odd_ff, TWO_MOD);
               cur_slot_in = slot_add(home_ff, slot_add(sq_ff, odd_ff));
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         if (wr_en) begin
            used_ff[chk_slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      home_ff     <= home_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      cur_slot_ff <= cur_slot_in;
      sq_ff       <= sq_in;
      odd_ff      <= odd_in;
      chk_used_ff <= chk_used_in;
      chk_last_ff <= chk_last_in;
      chk_slot_ff <= chk_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_after_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_PROBE))
      else $error("response without a probe phase");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(TABLE_SLOTS))
      else $error("probe count beyond table size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STAT_FOUND) |-> (rsp_ff.found_value == '0))
      else $error("nonzero value on a response that is not found");

   a_write_only_on_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (done && req_ff.action == ACT_INSERT))
      else $error("table write outside an insert completion");

endmodule

// File: rtl/qph_ram.sv
module qph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/tb_top.sv
module tb_top;
   import qph_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   qph_req_type req_data;
   logic        rsp_valid;
   qph_rsp_type rsp_data;

   logic                model_used [TABLE_SLOTS];
   logic [KEY_W-1:0]    model_key  [TABLE_SLOTS];
   logic [VAL_W-1:0]    model_value[TABLE_SLOTS];
   qph_rsp_type         pending_outcomes[$];
   logic [KEY_W-1:0]    known_keys[$];
   int                  failures;

   quadratic_probe_hash_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // applies one request to the table copy and returns the response it must give
   function automatic qph_rsp_type table_outcome(input qph_req_type r);
      int          home;
      int          s;
      qph_rsp_type o;
      home          = r.key % TABLE_SLOTS;
      o.found_value = '0;
      if (r.action == ACT_INSERT) begin
         o.status = STAT_FULL;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            s = (home + (i * i) % TABLE_SLOTS) % TABLE_SLOTS;
            if (!model_used[s] || model_key[s] == r.key) begin
               model_used[s]  = 1'b1;
               model_key[s]   = r.key;
               model_value[s] = r.value;
               o.status       = STAT_STORED;
               break;
            end
         end
      end else begin
         o.status = STAT_MISSING;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            s = (home + (i * i) % TABLE_SLOTS) % TABLE_SLOTS;
            if (!model_used[s]) begin
               break;
            end
            if (model_key[s] == r.key) begin
               o.status      = STAT_FOUND;
               o.found_value = model_value[s];
               break;
            end
         end
      end
      return o;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin
      qph_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            note_failure($sformatf("unexpected response status=%0d value=%08h",
                                   rsp_data.status, rsp_data.found_value));
         end else begin
            exp_rsp = pending_outcomes.pop_front();
            if (rsp_data.status !== exp_rsp.status ||
                rsp_data.found_value !== exp_rsp.found_value) begin
               note_failure($sformatf("status exp=%0d act=%0d, value exp=%08h act=%08h",
                                      exp_rsp.status, rsp_data.status,
                                      exp_rsp.found_value, rsp_data.found_value));
            end
         end
      end
   end

   task automatic send_request(input qph_req_type r, input int gap);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_outcomes.push_back(table_outcome(r));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic send_op(input qph_action_type act, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v);
      qph_req_type r;
      r.action = act;
      r.key    = k;
      r.value  = v;
      send_request(r, $urandom_range(0, 2));
   endtask

   task automatic test_basic_records();
      send_op(ACT_SEARCH, 31'd5, 32'h0);
      send_op(ACT_INSERT, 31'd0, 32'h0000_0000);
      send_op(ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_op(ACT_SEARCH, 31'd0, 32'hFFFF_FFFF);
      send_op(ACT_SEARCH, 31'h7FFF_FFFF, 32'h0);
      send_op(ACT_INSERT, 31'h7FFF_FFFF, 32'h1234_5678);
      send_op(ACT_SEARCH, 31'h7FFF_FFFF, 32'h0);
      send_op(ACT_SEARCH, 31'd16, 32'h0);
   endtask

   // five keys sharing home slot 3: only four distinct probe slots exist
   task automatic test_collision_chain();
      for (int k = 0; k < 4; k++) begin
         send_op(ACT_INSERT, 31'(3 + 16 * k), $urandom);
      end
      send_op(ACT_INSERT, 31'd67, 32'hA5A5_A5A5);
      send_op(ACT_SEARCH, 31'd67, 32'h0);
      send_op(ACT_SEARCH, 31'd51, 32'h0);
      send_op(ACT_INSERT, 31'd19, 32'h5A5A_5A5A);
      send_op(ACT_SEARCH, 31'd19, 32'h0);
   endtask

   task automatic test_random_traffic(input int count, input bit narrow_homes);
      qph_req_type r;
      int          roll;
      int          gap;
      int          quiet_run;
      quiet_run = 0;
      for (int n = 0; n < count; n++) begin
         roll    = $urandom_range(0, 99);
         r.key   = KEY_W'($urandom);
         r.value = $urandom;
         if (roll < 35 && known_keys.size() != 0) begin
            r.action = ACT_SEARCH;
            r.key    = known_keys[$urandom_range(0, known_keys.size() - 1)];
         end else if (roll < 55) begin
            r.action = ACT_SEARCH;
         end else if (roll < 80 && known_keys.size() != 0) begin
            r.action = ACT_INSERT;
            r.key    = known_keys[$urandom_range(0, known_keys.size() - 1)];
         end else begin
            r.action = ACT_INSERT;
            if (narrow_homes) begin
               r.key[3:0] = $urandom_range(0, 1) ? 4'd2 : 4'd0;
            end
            known_keys.push_back(r.key);
         end
         if (quiet_run > 0) begin
            gap = 0;
            quiet_run--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               quiet_run = $urandom_range(20, 60);
               gap       = 0;
            end else if (roll < 50) begin
               gap = 0;
            end else if (roll < 90) begin
               gap = $urandom_range(1, 3);
            end else begin
               gap = $urandom_range(8, 40);
            end
         end
         send_request(r, gap);
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      failures = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         model_used[i]  = 1'b0;
         model_key[i]   = '0;
         model_value[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_records();
      test_collision_chain();
      wait_drain();
      test_random_traffic(500, 1'b1);
      wait_drain();
      test_random_traffic(800, 1'b0);
      wait_drain();
      repeat (TABLE_SLOTS + 8) @(posedge clock);
      if (failures == 0 && pending_outcomes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
